FILE: rtl/uniform_bspline_point_evaluator_core_defines.svh
// Assertion macros for the uniform B-spline point evaluator.
`ifndef UNIFORM_BSPLINE_POINT_EVALUATOR_CORE_DEFINES_SVH
`define UNIFORM_BSPLINE_POINT_EVALUATOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, a, b)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

FILE: rtl/bspe_pkg.sv
// Types and constants shared by the B-spline evaluator modules.
package bspe_pkg;
    localparam int DATA_W = 32;
    localparam int FRAC_W = 30;
    localparam int QUOT_W = FRAC_W + 1;
    localparam int ADDR_W = 3;

    localparam logic       MODE_LOAD = 1'b0;
    localparam logic       MODE_EVAL = 1'b1;
    localparam logic       REG_STEP  = 1'b0;
    localparam logic       REG_LAST  = 1'b1;
    localparam logic [31:0] STEP_RESET = 32'd65536;
    localparam logic [5:0]  LAST_RESET = 6'd3;

    typedef struct packed {
        logic               mode;
        logic [5:0]         point_index;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] in_heading;
        logic [31:0]        query_time;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_heading;
    } t_res;
endpackage

FILE: rtl/bspe_ram.sv
// Generic single write port RAM with a registered read port.
module bspe_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/bspe_wdiv.sv
// Restoring divider that forms a Q1.30 blend weight, one quotient bit per cycle.
module bspe_wdiv import bspe_pkg::*; #(
    parameter int WW = 36
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WW-2:0]     i_num,
    input  logic [WW-2:0]     i_den,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(QUOT_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [WW-1:0]     r_rem, n_rem;
    logic [WW-1:0]     r_den, n_den;
    logic [QUOT_W-1:0] r_q, n_q;
    logic [WW-1:0]     trial;
    logic              ge;

    always_comb begin
        trial  = (r_cnt == '0) ? r_rem : {r_rem[WW-2:0], 1'b0};
        ge     = trial >= r_den;
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_q    = r_q;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = {1'b0, i_num};
            n_den  = {1'b0, i_den};
            n_q    = '0;
        end else if (r_busy) begin
            n_rem = ge ? trial - r_den : trial;
            n_q   = {r_q[QUOT_W-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

FILE: rtl/uniform_bspline_point_evaluator_core.sv
// Uniform B-spline point evaluator: control point store, sequencer and blend datapath.
// A load transfer writes one control point and leaves busy low. An evaluate transfer raises
// busy until its result strobe: a segment search (one subtract of step_time a cycle), a fetch
// of the control points from the point RAM, then for each of the DEGREE*(DEGREE+1)/2 blends a
// setup and a run of the shared restoring divider and a pass through the shared multiplier and
// adder for each of the four result fields. The result is on o_res for exactly one cycle marked
// by o_valid, and busy falls in that same cycle, so the receiver must take it then.
`include "uniform_bspline_point_evaluator_core_defines.svh"
module uniform_bspline_point_evaluator_core import bspe_pkg::*; #(
    parameter int DEGREE     = 3,
    parameter int MAX_POINTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_cmd              i_cmd,
    output logic              o_valid,
    output t_res              o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam int IW = $clog2(MAX_POINTS);
    localparam int NW = (IW > 6) ? IW : 6;
    localparam int CW = $clog2(DEGREE + 1);
    localparam int DW = DATA_W + CW;
    localparam int WW = DW + 1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SEEK  = 7'b0000010,
        ST_FETCH = 7'b0000100,
        ST_WPREP = 7'b0001000,
        ST_WDIV  = 7'b0010000,
        ST_MUL   = 7'b0100000,
        ST_ADD   = 7'b1000000
    } t_state;

    typedef logic [3:0][31:0] t_pt;

    t_state            r_state, n_state;
    logic [31:0]       r_step;
    logic [5:0]        r_last;
    logic [31:0]       r_u, n_u;
    logic [IW-1:0]     r_k, n_k;
    logic [CW:0]       r_fj, n_fj;
    logic [CW-1:0]     r_r, n_r;
    logic [CW-1:0]     r_i, n_i;
    logic [1:0]        r_c, n_c;
    logic [DW:0]       r_num, n_num;
    logic [DW-1:0]     r_den, n_den;
    logic              r_go, n_go;
    logic [QUOT_W-1:0] r_a, n_a;
    logic signed [63:0] r_prod, n_prod;
    logic              r_valid, n_valid;
    t_pt               r_p [DEGREE+1];
    t_pt               n_p [DEGREE+1];
    t_pt               rot_tmp;

    logic [31:0]       dt;
    logic [NW-1:0]     n_pts, segs_m1;
    logic [IW:0]       raddr_w;
    logic [IW-1:0]     raddr;
    logic [127:0]      rdata;
    logic              ld_we;
    logic [DW-1:0]     div_num;
    logic              div_done;
    logic [QUOT_W-1:0] div_quot;
    logic signed [32:0] diff;
    logic signed [64:0] prod_full;
    logic signed [34:0] sum;
    logic signed [31:0] res;
    logic              cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_LAST) ? {26'd0, r_last} : r_step;
    assign busy   = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
            r_last <= LAST_RESET;
        end else if (cfg_we) begin
            if (paddr[2] == REG_STEP) begin
                r_step <= pwdata;
            end else begin
                r_last <= pwdata[5:0];
            end
        end
    end

    always_comb begin
        dt = (r_step == '0) ? 32'd1 : r_step;
        n_pts = NW'(r_last);
        if (n_pts < NW'(DEGREE)) begin
            n_pts = NW'(DEGREE);
        end
        if (n_pts > NW'(MAX_POINTS - 1)) begin
            n_pts = NW'(MAX_POINTS - 1);
        end
        segs_m1 = n_pts - NW'(DEGREE);
        raddr_w = {1'b0, r_k} + (IW + 1)'(r_fj);
        if (raddr_w > (IW + 1)'(MAX_POINTS - 1)) begin
            raddr_w = (IW + 1)'(MAX_POINTS - 1);
        end
        raddr = raddr_w[IW-1:0];
    end

    assign ld_we = start && !busy && (i_cmd.mode == MODE_LOAD)
                   && ((NW + 1)'(i_cmd.point_index) < (NW + 1)'(MAX_POINTS));

    bspe_ram #(
        .WIDTH (128),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (IW'(i_cmd.point_index)),
        .i_wdata ({i_cmd.in_heading, i_cmd.in_z, i_cmd.in_y, i_cmd.in_x}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign div_num = (r_num > {1'b0, r_den}) ? r_den : r_num[DW-1:0];

    bspe_wdiv #(
        .WW (WW)
    ) u_wdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        diff      = $signed({r_p[DEGREE][0][31], r_p[DEGREE][0]})
                    - $signed({r_p[DEGREE-1][0][31], r_p[DEGREE-1][0]});
        prod_full = diff * $signed({1'b0, r_a});
        sum       = $signed({{3{r_p[DEGREE-1][0][31]}}, r_p[DEGREE-1][0]})
                    + $signed({r_prod[63], r_prod[63:FRAC_W]});
        if (sum > 35'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (sum < -35'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = sum[31:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_u     = r_u;
        n_k     = r_k;
        n_fj    = r_fj;
        n_r     = r_r;
        n_i     = r_i;
        n_c     = r_c;
        n_num   = r_num;
        n_den   = r_den;
        n_go    = 1'b0;
        n_a     = r_a;
        n_prod  = r_prod;
        n_valid = 1'b0;
        n_p     = r_p;
        rot_tmp = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start && (i_cmd.mode == MODE_EVAL)) begin
                    n_u     = i_cmd.query_time;
                    n_k     = '0;
                    n_state = ST_SEEK;
                end
            end
            ST_SEEK: begin
                if ((r_u > dt) && (NW'(r_k) < segs_m1)) begin
                    n_u = r_u - dt;
                    n_k = r_k + 1'b1;
                end else begin
                    if (r_u > dt) begin
                        n_u = dt;
                    end
                    n_fj    = '0;
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (r_fj != '0) begin
                    for (int e = 0; e < DEGREE; e++) begin
                        n_p[e] = r_p[e+1];
                    end
                    n_p[DEGREE] = rdata;
                end
                n_fj = r_fj + 1'b1;
                if (r_fj == (CW + 1)'(DEGREE + 1)) begin
                    n_r     = CW'(1);
                    n_i     = '0;
                    n_state = ST_WPREP;
                end
            end
            ST_WPREP: begin
                n_num   = (DW + 1)'(r_u) + (DW + 1)'(r_i) * (DW + 1)'(dt);
                n_den   = DW'(CW'(DEGREE) - r_r + 1'b1) * DW'(dt);
                n_go    = 1'b1;
                n_state = ST_WDIV;
            end
            ST_WDIV: begin
                if (div_done) begin
                    n_a     = div_quot;
                    n_c     = '0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod  = prod_full[63:0];
                n_state = ST_ADD;
            end
            ST_ADD: begin
                for (int l = 0; l < 3; l++) begin
                    n_p[DEGREE][l]   = r_p[DEGREE][l+1];
                    n_p[DEGREE-1][l] = r_p[DEGREE-1][l+1];
                end
                n_p[DEGREE][3]   = res;
                n_p[DEGREE-1][3] = r_p[DEGREE-1][0];
                n_c = r_c + 1'b1;
                if (r_c == 2'd3) begin
                    // Rotate the point line once so the next lower pair sits at the top.
                    rot_tmp = n_p[DEGREE];
                    for (int e = DEGREE; e >= 1; e--) begin
                        n_p[e] = n_p[e-1];
                    end
                    n_p[0] = rot_tmp;
                    if (r_i == CW'(DEGREE) - r_r) begin
                        // The step is done, so the line is turned back to its home position.
                        for (int q = 1; q <= DEGREE; q++) begin
                            if (CW'(q) <= r_r) begin
                                rot_tmp = n_p[DEGREE];
                                for (int e = DEGREE; e >= 1; e--) begin
                                    n_p[e] = n_p[e-1];
                                end
                                n_p[0] = rot_tmp;
                            end
                        end
                        n_i = '0;
                        if (r_r == CW'(DEGREE)) begin
                            n_valid = 1'b1;
                            n_state = ST_IDLE;
                        end else begin
                            n_r     = r_r + 1'b1;
                            n_state = ST_WPREP;
                        end
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_WPREP;
                    end
                end else begin
                    n_state = ST_MUL;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_go    <= 1'b0;
            r_fj    <= '0;
            r_r     <= '0;
            r_i     <= '0;
            r_c     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_go    <= n_go;
            r_fj    <= n_fj;
            r_r     <= n_r;
            r_i     <= n_i;
            r_c     <= n_c;
            r_k     <= n_k;
        end
        r_u    <= n_u;
        r_num  <= n_num;
        r_den  <= n_den;
        r_a    <= n_a;
        r_prod <= n_prod;
        r_p    <= n_p;
    end

    assign o_valid           = r_valid;
    assign o_res.out_x       = r_p[DEGREE][0];
    assign o_res.out_y       = r_p[DEGREE][1];
    assign o_res.out_z       = r_p[DEGREE][2];
    assign o_res.out_heading = r_p[DEGREE][3];

    `ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)
    `ASSERT_SAME(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    `ASSERT_NEXT(a_eval_busy, i_clk, i_rst_n, start && !busy && i_cmd.mode == MODE_EVAL, busy)
    `ASSERT_NEXT(a_load_free, i_clk, i_rst_n, start && !busy && i_cmd.mode == MODE_LOAD, !busy)
endmodule
